// ----- design/slrf_pkg.sv -----
// slrf_pkg: shared constants, types and field widths for the sliding-lag
// period refinement block. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package slrf_pkg;

    // window and lag geometry
    localparam int WIN_SAMPLES = 128;
    localparam int ADDR_W      = $clog2(WIN_SAMPLES);
    localparam int LOAD_W      = ADDR_W + 1;
    localparam int LAG_SPREAD  = 4;
    localparam int LAG_COUNT   = 2 * LAG_SPREAD + 1;
    localparam int LIDX_W      = $clog2(LAG_COUNT);
    localparam int NUM_POS     = WIN_SAMPLES / 2;
    localparam int POS_W       = $clog2(NUM_POS);
    localparam int SUB_W       = POS_W;
    localparam int LEN_W       = POS_W;
    localparam int IP_W        = 8;

    // field widths
    localparam int SMP_W   = 16;
    localparam int PER_W   = 16;
    localparam int SQ_W    = 2 * SMP_W;
    localparam int DSQ_W   = 2 * SMP_W + 1;
    localparam int SUM_W   = 40;
    localparam int SCORE_W = 18;

    // range check on the coarse period (Q8.8)
    localparam int PER_MIN  = LAG_SPREAD * 256;
    localparam int PER_MAX8 = (3 * WIN_SAMPLES - 8 * LAG_SPREAD) * 256;

    // score and offset arithmetic
    localparam int SCORE_ONE  = 65536;
    localparam int Q_SAT      = 131072;
    localparam int SCORE_FRAC = 16;
    localparam int SCORE_BITS = 18;
    localparam int OFS_BITS   = 9;
    localparam int Q_W        = 18;
    localparam int DIV_W      = 58;
    localparam int DCNT_W     = 5;

    // running sums of one lag
    typedef struct packed {
        logic [SUM_W-1:0] left;
        logic [SUM_W-1:0] right;
        logic [SUM_W-1:0] diff;
    } lag_sums_t;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] nbits;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } div_req_t;

endpackage

`default_nettype wire

// ----- design/slrf_cell.sv -----
// slrf_cell: one lag cell of the rotating chain, holding the three running sums.
// Depends on slrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slrf_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire slrf_pkg::lag_sums_t sums_in,
    output slrf_pkg::lag_sums_t    sums_out
);
    import slrf_pkg::*;

    lag_sums_t sums_reg;

    // take the neighbor's sums on every rotation step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else if (shift)
        begin
            sums_reg <= sums_in;
        end
    end

    assign sums_out = sums_reg;

endmodule

`default_nettype wire

// ----- design/slrf_div.sv -----
// slrf_div: restoring divider, one quotient bit per cycle, shared by the
// lag scores and the parabolic offset. Depends on slrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slrf_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire slrf_pkg::div_req_t req,
    output logic                  busy,
    output logic [slrf_pkg::Q_W-1:0] quot
);
    import slrf_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [Q_W-1:0]    q_reg;
    logic              busy_reg;
    logic              ge;

    assign ge = rem_reg >= den_reg;

    // control: busy from a start until the counter loaded with nbits runs down
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: compare, subtract, shift the divisor down
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            den_reg <= den_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- design/sliding_lag_period_refine.sv -----
// sliding_lag_period_refine: top level with sample memory, sequencer, pair
// accumulator, lag cell chain and result register. Depends on slrf_pkg,
// slrf_cell and slrf_div.
//
// Usage: samples stream in on the s_ group, one beat per cycle while loading;
// tlast marks the final sample and that beat carries the coarse period in Q8.8.
// The block then drops s_tready and works on the window. An out-of-range period
// gives one beat with tuser set and tlast set. Otherwise 64 result beats
// follow, one per window position, the last one with tlast and the period
// change. Loading sets up the nine lag sums by walking the window once per
// lag, with len pairs per lag, len = 16..36. For each position the block then
// makes, per lag, two pair updates and one score division in the shared
// divider, followed by one offset division and one output beat.
// Each result waits in the output register until m_tready; a stalled
// receiver stalls the sequencer. After the last result beat s_tready rises
// again. Reset clears the control state and returns the block to loading;
// no memory clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module sliding_lag_period_refine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sample[15:0], coarse_period[31:16]
    input  wire logic        s_tlast,   // window_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // refined_period[15:0], period_change[31:16]
    output logic             m_tuser,   // invalid_period
    output logic             m_tlast    // run_end
);
    import slrf_pkg::*;

    typedef enum logic [8:0] {
        ST_LOAD   = 9'b000000001,
        ST_INIT   = 9'b000000010,
        ST_IDRAIN = 9'b000000100,
        ST_SLIDE  = 9'b000001000,
        ST_SLIDE2 = 9'b000010000,
        ST_SWAIT  = 9'b000100000,
        ST_REFINE = 9'b001000000,
        ST_RWAIT  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [LOAD_W-1:0] load_cnt_reg;
    logic [LIDX_W-1:0] lidx_reg;
    logic [LEN_W-1:0]  j_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [SUB_W-1:0]  sub_reg;

    logic in_fire, out_fire, load_we, bad_per;
    logic [PER_W-1:0] per_in;

    // sample memory
    logic [SMP_W-1:0]        mem [WIN_SAMPLES];
    logic [ADDR_W-1:0]       addr_a, addr_b;
    logic signed [SMP_W-1:0] rd_a_reg, rd_b_reg;

    // pair pipeline
    logic issue, issue_sub;
    logic v1_reg, s1_reg, v2_reg, s2_reg;
    logic [SQ_W-1:0]  pa_reg, pb_reg;
    logic [DSQ_W-1:0] pd_reg;
    logic signed [SQ_W-1:0]    sqa, sqb;
    logic signed [SMP_W:0]     dab;
    logic signed [2*SMP_W+1:0] sqd;
    logic pipe_empty;

    lag_sums_t acc_reg;
    lag_sums_t ring [LAG_COUNT];
    lag_sums_t head;
    logic      rot;

    // divider and scoring
    div_req_t         div_req;
    logic             div_busy;
    logic [Q_W-1:0]   div_q;
    logic [SUM_W:0]   pw;
    logic             pw_zero_reg, sat_reg;
    logic [Q_W-1:0]   q_cl;
    logic signed [SCORE_W:0]   score_wide;
    logic signed [SCORE_W-1:0] score;

    // best lag tracking
    logic [LIDX_W-1:0]         best_reg;
    logic signed [SCORE_W-1:0] a_reg, b_reg, c_reg, prev_reg;
    logic                      capc_reg;

    // parabolic offset
    logic signed [SCORE_W:0]   c_m_a;
    logic signed [SCORE_W+8:0] numo;
    logic [SCORE_W+8:0]        mag;
    logic signed [SCORE_W+1:0] curv;
    logic [DIV_W-1:0]          ofs_num, ofs_den;
    logic                      neg_reg, okofs_reg;
    logic [IP_W-1:0]           lag_best;
    logic signed [PER_W+1:0]   base, ofs, ref18;
    logic [PER_W-1:0]          refined;
    logic [PER_W-1:0]          first_reg;
    logic signed [PER_W:0]     chg17;
    logic [PER_W-1:0]          chg;
    logic                      is_last;

    // lag geometry
    logic [IP_W-1:0]   lag_val;
    logic [ADDR_W-1:0] lag7, r2, l2, r1;
    logic [LEN_W-1:0]  len_val;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign per_in   = s_tdata[31:16];
    assign load_we  = in_fire && (load_cnt_reg < LOAD_W'(WIN_SAMPLES));
    assign bad_per  = (per_in < PER_W'(PER_MIN)) ||
                      ({per_in, 3'b000} > (PER_W+3)'(PER_MAX8));

    assign lag_val = ip_reg - IP_W'(LAG_SPREAD) + IP_W'(lidx_reg);
    assign lag7    = lag_val[ADDR_W-1:0];
    assign len_val = sub_reg + LEN_W'(LAG_SPREAD) - LEN_W'(lidx_reg);
    assign r2      = ADDR_W'(pos_reg) + ADDR_W'(sub_reg) + ip_reg[ADDR_W-1:0];
    assign l2      = r2 - lag7;
    assign r1      = ADDR_W'(pos_reg) + lag7;

    // read addresses per phase
    always_comb
    begin
        addr_a    = ADDR_W'(j_reg);
        addr_b    = ADDR_W'(j_reg) + lag7;
        issue     = 1'b0;
        issue_sub = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                issue = 1'b1;
            end
            ST_SLIDE:
            begin
                addr_a = l2;
                addr_b = r2;
                issue  = 1'b1;
            end
            ST_SLIDE2:
            begin
                addr_a    = ADDR_W'(pos_reg);
                addr_b    = r1;
                issue     = 1'b1;
                issue_sub = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // memory write and two registered read ports
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[load_cnt_reg[ADDR_W-1:0]] <= s_tdata[SMP_W-1:0];
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // products of the pair
    assign sqa = rd_a_reg * rd_a_reg;
    assign sqb = rd_b_reg * rd_b_reg;
    assign dab = (SMP_W+1)'(rd_a_reg) - (SMP_W+1)'(rd_b_reg);
    assign sqd = dab * dab;

    assign pipe_empty = !v1_reg && !v2_reg;
    assign head       = ring[0];
    assign pw         = {1'b0, head.left} + {1'b0, head.right};

    // score from the divider result
    assign q_cl = (sat_reg || (div_q > Q_W'(Q_SAT))) ? Q_W'(Q_SAT) : div_q;
    assign score_wide = (SCORE_W+1)'(SCORE_ONE) - $signed({1'b0, q_cl});
    assign score = pw_zero_reg ? '0 : score_wide[SCORE_W-1:0];

    assign rot = ((state_reg == ST_IDRAIN) && pipe_empty) ||
                 ((state_reg == ST_SWAIT) && pipe_empty && !div_busy);

    // lag cell chain, rotating toward cell 0
    for (genvar k = 0; k < LAG_COUNT; k++)
    begin : g_cell
        lag_sums_t cin;
        if (k == LAG_COUNT - 1)
        begin : g_tail
            assign cin = acc_reg;
        end
        else
        begin : g_mid
            assign cin = ring[k+1];
        end
        slrf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (rot),
            .sums_in  (cin),
            .sums_out (ring[k])
        );
    end

    // parabolic offset operands
    assign c_m_a   = (SCORE_W+1)'(c_reg) - (SCORE_W+1)'(a_reg);
    assign numo    = {c_m_a, 8'b0};
    assign mag     = numo[SCORE_W+8] ? (SCORE_W+9)'(-numo) : (SCORE_W+9)'(numo);
    assign curv    = {b_reg[SCORE_W-1], b_reg, 1'b0} - (SCORE_W+2)'(a_reg)
                     - (SCORE_W+2)'(c_reg);
    assign ofs_num = DIV_W'({mag, 1'b0}) + DIV_W'({curv, 1'b0});
    assign ofs_den = DIV_W'({curv, 10'b0});

    // divider requests
    always_comb
    begin
        div_req.start = (state_reg == ST_SLIDE) || (state_reg == ST_REFINE);
        if (state_reg == ST_REFINE)
        begin
            div_req.nbits = DCNT_W'(OFS_BITS);
            div_req.num   = ofs_num;
            div_req.den   = ofs_den;
        end
        else
        begin
            div_req.nbits = DCNT_W'(SCORE_BITS);
            div_req.num   = DIV_W'({head.diff, SCORE_FRAC'(0)});
            div_req.den   = DIV_W'({pw, (SCORE_BITS-1)'(0)});
        end
    end

    slrf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // refined period and change
    assign lag_best = ip_reg - IP_W'(LAG_SPREAD) + IP_W'(best_reg);
    assign base     = $signed({2'b00, lag_best, 8'b0});
    assign ofs      = okofs_reg ? $signed((PER_W+2)'(div_q[OFS_BITS-1:0])) : '0;
    assign ref18    = neg_reg ? base - ofs : base + ofs;
    assign refined  = ref18[PER_W+1] ? '0 :
                      (ref18[PER_W] ? {PER_W{1'b1}} : ref18[PER_W-1:0]);
    assign is_last  = (pos_reg == POS_W'(NUM_POS - 1));
    assign chg17    = $signed({1'b0, refined}) - $signed({1'b0, first_reg});
    assign chg      = chg17[PER_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = bad_per ? ST_OUT : ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (j_reg == len_val - LEN_W'(1))
                begin
                    state_next = ST_IDRAIN;
                end
            end
            ST_IDRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = (lidx_reg == LIDX_W'(LAG_COUNT - 1)) ? ST_SLIDE : ST_INIT;
                end
            end
            ST_SLIDE:  state_next = ST_SLIDE2;
            ST_SLIDE2: state_next = ST_SWAIT;
            ST_SWAIT:
            begin
                if (rot)
                begin
                    state_next = (lidx_reg == LIDX_W'(LAG_COUNT - 1)) ? ST_REFINE : ST_SLIDE;
                end
            end
            ST_REFINE: state_next = ST_RWAIT;
            ST_RWAIT:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = m_tlast ? ST_LOAD : ST_SLIDE;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            lidx_reg     <= '0;
            j_reg        <= '0;
            pos_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid     <= 1'b0;
            capc_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (in_fire)
            begin
                if (s_tlast)
                begin
                    load_cnt_reg <= '0;
                    lidx_reg     <= '0;
                    j_reg        <= '0;
                    pos_reg      <= '0;
                end
                else if (load_we)
                begin
                    load_cnt_reg <= load_cnt_reg + LOAD_W'(1);
                end
            end
            if (state_reg == ST_INIT)
            begin
                j_reg <= j_reg + LEN_W'(1);
            end
            if (rot)
            begin
                j_reg    <= '0;
                lidx_reg <= (lidx_reg == LIDX_W'(LAG_COUNT - 1)) ? '0 : lidx_reg + LIDX_W'(1);
            end
            if ((state_reg == ST_SWAIT) && rot)
            begin
                if ((lidx_reg == '0) || (score > b_reg))
                begin
                    capc_reg <= 1'b1;
                end
                else if (capc_reg)
                begin
                    capc_reg <= 1'b0;
                end
            end
            if (((state_reg == ST_LOAD) && in_fire && s_tlast && bad_per) ||
                ((state_reg == ST_RWAIT) && !div_busy))
            begin
                m_tvalid <= 1'b1;
            end
            else if (out_fire)
            begin
                m_tvalid <= 1'b0;
                if (!m_tlast)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_reg <= issue_sub;
        s2_reg <= s1_reg;
        if (v1_reg)
        begin
            pa_reg <= SQ_W'(sqa);
            pb_reg <= SQ_W'(sqb);
            pd_reg <= sqd[DSQ_W-1:0];
        end
        // window end: latch period, pick the sub-window length
        if (in_fire && s_tlast)
        begin
            ip_reg  <= per_in[PER_W-1:8];
            sub_reg <= (per_in[PER_W-1:8] > IP_W'(WIN_SAMPLES / 4)) ?
                       SUB_W'(IP_W'(WIN_SAMPLES / 2) - per_in[PER_W-1:8]) :
                       SUB_W'(WIN_SAMPLES / 4);
            acc_reg <= '0;
        end
        else if ((state_reg == ST_IDRAIN) && rot)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_SLIDE)
        begin
            acc_reg <= head;
        end
        else if (v2_reg)
        begin
            if (s2_reg)
            begin
                acc_reg.left  <= acc_reg.left  - SUM_W'(pa_reg);
                acc_reg.right <= acc_reg.right - SUM_W'(pb_reg);
                acc_reg.diff  <= acc_reg.diff  - SUM_W'(pd_reg);
            end
            else
            begin
                acc_reg.left  <= acc_reg.left  + SUM_W'(pa_reg);
                acc_reg.right <= acc_reg.right + SUM_W'(pb_reg);
                acc_reg.diff  <= acc_reg.diff  + SUM_W'(pd_reg);
            end
        end
        // score flags for the lag at the head of the chain
        if (state_reg == ST_SLIDE)
        begin
            pw_zero_reg <= (pw == '0);
            sat_reg     <= {3'b000, head.diff} >= {pw, 2'b00};
        end
        // best lag and its neighbor scores
        if ((state_reg == ST_SWAIT) && rot)
        begin
            prev_reg <= score;
            if ((lidx_reg == '0) || (score > b_reg))
            begin
                best_reg <= lidx_reg;
                b_reg    <= score;
                a_reg    <= prev_reg;
            end
            else if (capc_reg)
            begin
                c_reg <= score;
            end
        end
        if (state_reg == ST_REFINE)
        begin
            neg_reg   <= numo[SCORE_W+8];
            okofs_reg <= (best_reg != '0) && (best_reg != LIDX_W'(LAG_COUNT - 1)) &&
                         (curv > 0);
        end
        // result beat
        if ((state_reg == ST_LOAD) && in_fire && s_tlast && bad_per)
        begin
            m_tdata <= '0;
            m_tuser <= 1'b1;
            m_tlast <= 1'b1;
        end
        else if ((state_reg == ST_RWAIT) && !div_busy)
        begin
            if (pos_reg == '0)
            begin
                first_reg <= refined;
            end
            m_tuser <= 1'b0;
            m_tlast <= is_last;
            if (is_last)
            begin
                if (chg17 > 17'sd32767)
                begin
                    m_tdata <= {16'h7FFF, refined};
                end
                else if (chg17 < -17'sd32768)
                begin
                    m_tdata <= {16'h8000, refined};
                end
                else
                begin
                    m_tdata <= {chg, refined};
                end
            end
            else
            begin
                m_tdata <= {16'h0000, refined};
            end
        end
    end

`ifndef SYNTH
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 32'h0)))
        else $error("invalid result not a single zero last beat");

    a_change_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[31:16] == 16'h0))
        else $error("period change on a non-last beat");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");

    a_rot_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rot |-> (!v1_reg && !v2_reg && !issue))
        else $error("chain rotated with pair updates in flight");
`endif

endmodule

`default_nettype wire
